[hw/rtl/gidl_pkg.sv]
// shared types and constants of the gate indicator lamp decoder
`default_nettype none
package gidl_pkg;

    // history ring depth and number of agreeing error codes
    localparam int WINDOW = 128;
    localparam int VOTES  = 3;

    // derived widths
    localparam int WIN_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int GPOS_W = $clog2(WINDOW + 128);
    localparam int VOTE_W = (VOTES > 1) ? $clog2(VOTES) : 1;

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_MIN   = 3'd0,
        CFG_ERROR_OFFSET  = 3'd1,
        CFG_ERROR_PERIOD  = 3'd2,
        CFG_MOTION_OFFSET = 3'd3,
        CFG_MOTION_PERIOD = 3'd4
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_SILENCE_MIN   = 7'd30;
    localparam logic [CFG_W-1:0] RST_ERROR_OFFSET  = 7'd5;
    localparam logic [CFG_W-1:0] RST_ERROR_PERIOD  = 7'd10;
    localparam logic [CFG_W-1:0] RST_MOTION_OFFSET = 7'd3;
    localparam logic [CFG_W-1:0] RST_MOTION_PERIOD = 7'd6;

    // bit counts of the gathered patterns
    localparam int MOTION_BITS = 8;
    localparam int ERROR_BITS  = 16;

    // lamp patterns
    localparam logic [7:0]  PAT_OPEN_A  = 8'h33;
    localparam logic [7:0]  PAT_OPEN_B  = 8'hCC;
    localparam logic [7:0]  PAT_CLOSE_A = 8'hAA;
    localparam logic [7:0]  PAT_CLOSE_B = 8'h55;
    localparam logic [15:0] CODE_MAINS   = 16'h0005;
    localparam logic [15:0] CODE_BATTERY = 16'h0015;

    // input commands
    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_EVALUATE = 1'b1;

    // reported gate state
    typedef enum logic [2:0] {
        GS_UNKNOWN = 3'd0,
        GS_OPEN    = 3'd1,
        GS_CLOSED  = 3'd2,
        GS_OPENING = 3'd3,
        GS_CLOSING = 3'd4,
        GS_MAINS   = 3'd5,
        GS_BATTERY = 3'd6
    } t_gate_state;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PSCAN,
        ST_MGATH,
        ST_ESCAN,
        ST_EGATH,
        ST_VOTE,
        ST_DONE
    } t_seq_state;

endpackage
`default_nettype wire

[hw/rtl/gidl_ifs.sv]
// request channels of the gate indicator lamp decoder
`default_nettype none
interface gidl_in_if;
    logic valid;
    logic ready;
    logic command;
    logic lamp_on;

    modport source (output valid, output command, output lamp_on, input ready);
    modport sink   (input valid, input command, input lamp_on, output ready);
endinterface

interface gidl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] gate_state;
    logic       state_changed;

    modport source (output valid, output gate_state, output state_changed, input ready);
    modport sink   (input valid, input gate_state, input state_changed, output ready);
endinterface
`default_nettype wire

[hw/rtl/gate_indicator_light_decoder_core.sv]
// Gate indicator lamp decoder: one result per request. A sample request
// stores one lamp bit in a 128-entry history memory. An evaluate request
// walks the history through the memory's single read port, one bit per
// cycle: a transition scan, a motion gather, then, if no motion pattern
// matched, a silence scan and an error gather, plus a vote and a
// completion state. Each result waits in an output register, and the next
// request is taken as soon as the sequencer is back in idle. Reset clears
// the history at once through per-entry valid bits. Configuration is to
// be written by the user only while no request is in progress; the block
// itself does not enforce it.
`default_nettype none
module gate_indicator_light_decoder_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    gidl_in_if.sink                                i_in,
    gidl_out_if.source                             o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [gidl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gidl_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int WIN_W  = gidl_pkg::WIN_W;
    localparam int CNT_W  = gidl_pkg::CNT_W;
    localparam int GPOS_W = gidl_pkg::GPOS_W;
    localparam int VOTE_W = gidl_pkg::VOTE_W;
    localparam int CFG_W  = gidl_pkg::CFG_W;

    // configuration registers
    logic [CFG_W-1:0] r_silence_min;
    logic [CFG_W-1:0] r_error_offset;
    logic [CFG_W-1:0] r_error_period;
    logic [CFG_W-1:0] r_motion_offset;
    logic [CFG_W-1:0] r_motion_period;

    // sequencer and datapath
    gidl_pkg::t_seq_state  r_state, n_state;
    gidl_pkg::t_gate_state r_cur;
    gidl_pkg::t_gate_state r_next, n_next;
    gidl_pkg::t_gate_state r_err, n_err;
    logic [WIN_W-1:0]  r_wslot;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_first, n_first;
    logic [CNT_W-1:0]  r_zeros, n_zeros;
    logic [GPOS_W-1:0] r_gpos, n_gpos;
    logic [4:0]        r_gb, n_gb;
    logic [15:0]       r_acc, n_acc;

    // history memory and its read pipe
    logic              r_mem [gidl_pkg::WINDOW];
    logic              r_vld [gidl_pkg::WINDOW];
    logic              r_rd_go;
    logic              r_rd_data;
    logic [CNT_W-1:0]  r_rd_pos;
    logic [3:0]        r_rd_bit;
    logic              rd_req;
    logic [GPOS_W-1:0] rd_pos;
    logic [WIN_W-1:0]  rd_addr;

    // vote ring
    gidl_pkg::t_gate_state r_votes [gidl_pkg::VOTES];
    logic [VOTE_W-1:0]     r_eslot;
    logic                  vote_wr;
    logic                  vote_all;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_out_state;
    logic        r_out_chg;
    logic        out_load;
    logic        out_free;

    // handshakes
    logic in_accept;
    logic wr_en;

    // shared gather unit control
    logic [4:0]       g_nbits;
    logic [CFG_W-1:0] g_period;
    logic             g_req;
    logic             g_done;

    assign i_in.ready = (r_state == gidl_pkg::ST_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;
    assign wr_en      = in_accept && (i_in.command == gidl_pkg::CMD_SAMPLE);
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.gate_state    = r_out_state;
    assign o_out.state_changed = r_out_chg;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_min   <= gidl_pkg::RST_SILENCE_MIN;
            r_error_offset  <= gidl_pkg::RST_ERROR_OFFSET;
            r_error_period  <= gidl_pkg::RST_ERROR_PERIOD;
            r_motion_offset <= gidl_pkg::RST_MOTION_OFFSET;
            r_motion_period <= gidl_pkg::RST_MOTION_PERIOD;
        end else if (i_cfg_we) begin
            unique case (gidl_pkg::t_cfg_idx'(i_cfg_idx))
                gidl_pkg::CFG_SILENCE_MIN:   r_silence_min   <= i_cfg_data;
                gidl_pkg::CFG_ERROR_OFFSET:  r_error_offset  <= i_cfg_data;
                gidl_pkg::CFG_ERROR_PERIOD:  r_error_period  <= i_cfg_data;
                gidl_pkg::CFG_MOTION_OFFSET: r_motion_offset <= i_cfg_data;
                gidl_pkg::CFG_MOTION_PERIOD: r_motion_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // history memory: write on samples, registered read while evaluating
    assign rd_addr = r_wslot + rd_pos[WIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wslot] <= i_in.lamp_on;
        end
        r_rd_data <= r_mem[rd_addr] & r_vld[rd_addr];
        r_rd_pos  <= CNT_W'(rd_pos);
        r_rd_bit  <= r_gb[3:0];
    end

    // valid bits stand for the dark reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gidl_pkg::WINDOW; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[r_wslot] <= 1'b1;
        end
    end

    // write slot and read pipe flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_rd_go <= 1'b0;
        end else begin
            if (wr_en) begin
                r_wslot <= r_wslot + WIN_W'(1);
            end
            r_rd_go <= rd_req;
        end
    end

    // vote ring update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gidl_pkg::VOTES; i++) begin
                r_votes[i] <= gidl_pkg::GS_UNKNOWN;
            end
            r_eslot <= '0;
        end else if (vote_wr) begin
            r_votes[r_eslot] <= n_err;
            if (r_eslot == VOTE_W'(gidl_pkg::VOTES - 1)) begin
                r_eslot <= '0;
            end else begin
                r_eslot <= r_eslot + VOTE_W'(1);
            end
        end
    end

    // all votes agree with the latest code
    always_comb begin
        vote_all = 1'b1;
        for (int i = 0; i < gidl_pkg::VOTES; i++) begin
            if (r_votes[i] != r_err) begin
                vote_all = 1'b0;
            end
        end
    end

    // gather unit: one bit position per cycle, stops past the newest sample
    always_comb begin
        if (r_state == gidl_pkg::ST_EGATH) begin
            g_nbits  = 5'(gidl_pkg::ERROR_BITS);
            g_period = r_error_period;
        end else begin
            g_nbits  = 5'(gidl_pkg::MOTION_BITS);
            g_period = r_motion_period;
        end
        g_req  = (r_gb < g_nbits) && (r_gpos < GPOS_W'(gidl_pkg::WINDOW));
        g_done = !g_req && !r_rd_go;
    end

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gidl_pkg::ST_IDLE;
            r_cur   <= gidl_pkg::GS_UNKNOWN;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_cur <= r_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next  <= n_next;
        r_err   <= n_err;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        r_zeros <= n_zeros;
        r_gpos  <= n_gpos;
        r_gb    <= n_gb;
        r_acc   <= n_acc;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_state <= r_next;
            r_out_chg   <= (r_next != r_cur);
        end
    end

    // sequencer next state and datapath
    always_comb begin
        n_state  = r_state;
        n_next   = r_next;
        n_err    = r_err;
        n_cnt    = r_cnt;
        n_first  = r_first;
        n_zeros  = r_zeros;
        n_gpos   = r_gpos;
        n_gb     = r_gb;
        n_acc    = r_acc;
        rd_req   = 1'b0;
        rd_pos   = GPOS_W'(r_cnt);
        vote_wr  = 1'b0;
        out_load = 1'b0;

        unique case (r_state)
            gidl_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_next = r_cur;
                    if (i_in.command == gidl_pkg::CMD_SAMPLE) begin
                        if (r_cur == gidl_pkg::GS_OPEN && !i_in.lamp_on) begin
                            n_next = gidl_pkg::GS_CLOSING;
                        end
                        if (r_cur == gidl_pkg::GS_CLOSED && i_in.lamp_on) begin
                            n_next = gidl_pkg::GS_OPENING;
                        end
                        n_state = gidl_pkg::ST_DONE;
                    end else begin
                        n_cnt   = '0;
                        n_state = gidl_pkg::ST_PSCAN;
                    end
                end
            end

            // find the first transition, oldest sample first
            gidl_pkg::ST_PSCAN: begin
                rd_req = (r_cnt < CNT_W'(gidl_pkg::WINDOW));
                if (r_rd_go) begin
                    if (r_rd_pos == '0) begin
                        n_first = r_rd_data;
                    end else if (r_rd_data != r_first) begin
                        rd_req  = 1'b0;
                        n_gpos  = GPOS_W'(r_rd_pos) + GPOS_W'(r_motion_offset);
                        n_gb    = '0;
                        n_acc   = '0;
                        n_state = gidl_pkg::ST_MGATH;
                    end else if (r_rd_pos == CNT_W'(gidl_pkg::WINDOW - 1)) begin
                        rd_req  = 1'b0;
                        n_next  = r_first ? gidl_pkg::GS_OPEN : gidl_pkg::GS_CLOSED;
                        n_state = gidl_pkg::ST_DONE;
                    end
                end
                if (rd_req) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            // motion pattern gather
            gidl_pkg::ST_MGATH: begin
                rd_req = g_req;
                rd_pos = r_gpos;
                if (g_req) begin
                    n_gpos = r_gpos + GPOS_W'(g_period);
                    n_gb   = r_gb + 5'd1;
                end
                if (r_rd_go) begin
                    n_acc = r_acc | (16'(r_rd_data) << r_rd_bit);
                end
                if (g_done) begin
                    if (r_acc[7:0] == gidl_pkg::PAT_OPEN_A
                            || r_acc[7:0] == gidl_pkg::PAT_OPEN_B) begin
                        n_next  = gidl_pkg::GS_OPENING;
                        n_state = gidl_pkg::ST_DONE;
                    end else if (r_acc[7:0] == gidl_pkg::PAT_CLOSE_A
                            || r_acc[7:0] == gidl_pkg::PAT_CLOSE_B) begin
                        n_next  = gidl_pkg::GS_CLOSING;
                        n_state = gidl_pkg::ST_DONE;
                    end else begin
                        n_cnt   = '0;
                        n_zeros = '0;
                        n_state = gidl_pkg::ST_ESCAN;
                    end
                end
            end

            // find the end of a long dark stretch
            gidl_pkg::ST_ESCAN: begin
                rd_req = (r_cnt < CNT_W'(gidl_pkg::WINDOW));
                if (r_rd_go) begin
                    if (!r_rd_data) begin
                        n_zeros = r_zeros + CNT_W'(1);
                    end else if (r_zeros >= CNT_W'(r_silence_min)) begin
                        rd_req = 1'b0;
                        if (r_rd_pos != '0) begin
                            n_gpos  = GPOS_W'(r_rd_pos) + GPOS_W'(r_error_offset);
                            n_gb    = '0;
                            n_acc   = '0;
                            n_state = gidl_pkg::ST_EGATH;
                        end else begin
                            n_state = gidl_pkg::ST_DONE;
                        end
                    end else begin
                        n_zeros = '0;
                    end
                    // newest sample seen without a silence end
                    if (n_state == gidl_pkg::ST_ESCAN
                            && r_rd_pos == CNT_W'(gidl_pkg::WINDOW - 1)) begin
                        n_state = gidl_pkg::ST_DONE;
                    end
                end
                if (rd_req) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            // error code gather
            gidl_pkg::ST_EGATH: begin
                rd_req = g_req;
                rd_pos = r_gpos;
                if (g_req) begin
                    n_gpos = r_gpos + GPOS_W'(g_period);
                    n_gb   = r_gb + 5'd1;
                end
                if (r_rd_go) begin
                    n_acc = r_acc | (16'(r_rd_data) << r_rd_bit);
                end
                if (g_done) begin
                    if (r_acc == gidl_pkg::CODE_MAINS) begin
                        n_err   = gidl_pkg::GS_MAINS;
                        vote_wr = 1'b1;
                        n_state = gidl_pkg::ST_VOTE;
                    end else if (r_acc == gidl_pkg::CODE_BATTERY) begin
                        n_err   = gidl_pkg::GS_BATTERY;
                        vote_wr = 1'b1;
                        n_state = gidl_pkg::ST_VOTE;
                    end else begin
                        n_state = gidl_pkg::ST_DONE;
                    end
                end
            end

            // report the code only when the whole ring agrees
            gidl_pkg::ST_VOTE: begin
                if (vote_all) begin
                    n_next = r_err;
                end
                n_state = gidl_pkg::ST_DONE;
            end

            // hand the result to the output register
            gidl_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = gidl_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gidl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
